// ----- rtl/glyph_alpha_rle_decoder_top_assert.svh -----
// assertion helpers shared by the decoder modules
`ifndef GLYPH_ALPHA_RLE_DECODER_TOP_ASSERT_SVH
`define GLYPH_ALPHA_RLE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GARLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/garle_pkg.sv -----
`default_nettype none

package garle_pkg;

  // command nibbles
  localparam logic [3:0] CMD_RUN_FULL = 4'hC;
  localparam logic [3:0] CMD_RUN_ZERO = 4'hD;
  localparam logic [3:0] CMD_RUN_VAL  = 4'hE;
  localparam logic [3:0] CMD_LITERAL  = 4'hF;

  // decoder modes
  localparam logic [2:0] MODE_CMD   = 3'd0;
  localparam logic [2:0] MODE_LIT   = 3'd1;
  localparam logic [2:0] MODE_COUNT = 3'd2;
  localparam logic [2:0] MODE_VALUE = 3'd3;
  localparam logic [2:0] MODE_STOP  = 3'd4;

  // pending run kinds
  localparam logic [1:0] PCMD_ZERO  = 2'd0;
  localparam logic [1:0] PCMD_FULL  = 2'd1;
  localparam logic [1:0] PCMD_VALUE = 2'd2;

  // register map
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int unsigned NUM_SLOTS = 3;

  localparam logic [7:0] ALPHA_MAP [12] = '{
    8'd0, 8'd16, 8'd32, 8'd48, 8'd64, 8'd96,
    8'd128, 8'd160, 8'd192, 8'd224, 8'd240, 8'd255
  };

  // result of decoding one nibble
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] pcmd;
    logic [3:0] pcount;
    logic       want;
    logic [7:0] alpha;
    logic [3:0] rlen;
  } nib_res_t;

  // one output run
  typedef struct packed {
    logic [7:0]  alpha;
    logic [15:0] len;
    logic        last;
  } run_t;

  // up to three runs made by one byte
  typedef struct packed {
    logic [1:0] cnt;
    run_t [NUM_SLOTS-1:0] slot;
  } bundle_t;

  function automatic logic [7:0] map_alpha(input logic [3:0] idx);
    logic [7:0] a;
    a = 8'd255;
    if (idx < CMD_RUN_FULL) begin
      a = ALPHA_MAP[idx];
    end
    return a;
  endfunction

  function automatic nib_res_t take_cmd(input nib_res_t cur, input logic [3:0] v);
    nib_res_t r;
    r = cur;
    if (v == CMD_LITERAL) begin
      r.mode = MODE_LIT;
    end else if (v == CMD_RUN_ZERO) begin
      r.pcmd = PCMD_ZERO;
      r.mode = MODE_COUNT;
    end else if (v == CMD_RUN_FULL) begin
      r.pcmd = PCMD_FULL;
      r.mode = MODE_COUNT;
    end else if (v == CMD_RUN_VAL) begin
      r.pcmd = PCMD_VALUE;
      r.mode = MODE_COUNT;
    end else begin
      r.mode = MODE_STOP;
    end
    return r;
  endfunction

  function automatic nib_res_t nib_step(input logic [2:0] mode, input logic [1:0] pcmd,
                                        input logic [3:0] pcount, input logic [3:0] v);
    nib_res_t r;
    r.mode   = mode;
    r.pcmd   = pcmd;
    r.pcount = pcount;
    r.want   = 1'b0;
    r.alpha  = 8'd0;
    r.rlen   = 4'd0;
    unique case (mode)
      MODE_CMD: begin
        r = take_cmd(r, v);
      end
      MODE_LIT: begin
        if (v < CMD_RUN_FULL) begin
          r.want  = 1'b1;
          r.alpha = map_alpha(v);
          r.rlen  = 4'd1;
        end else begin
          r = take_cmd(r, v);
        end
      end
      MODE_COUNT: begin
        if (pcmd == PCMD_VALUE) begin
          r.pcount = v;
          r.mode   = MODE_VALUE;
        end else begin
          r.want  = 1'b1;
          r.alpha = (pcmd == PCMD_ZERO) ? 8'd0 : 8'd255;
          r.rlen  = v;
          r.mode  = MODE_CMD;
        end
      end
      MODE_VALUE: begin
        r.want  = 1'b1;
        r.alpha = map_alpha(v);
        r.rlen  = pcount;
        r.mode  = MODE_CMD;
      end
      default: begin
        // stopped: ignore nibbles until the last byte
      end
    endcase
    return r;
  endfunction

  // shorten a run to the pixels that remain
  function automatic logic [15:0] clip_len(input logic want, input logic [3:0] rlen,
                                           input logic [15:0] left);
    logic [15:0] l;
    l = {12'd0, rlen};
    if (!want) begin
      l = 16'd0;
    end else if (l > left) begin
      l = left;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/garle_cfg.sv -----
`default_nettype none

module garle_cfg #(
  parameter int unsigned MAX_GLYPH_DIM = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output logic      [15:0] total_r
);
  import garle_pkg::*;

  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [7:0]  width_lim;
  logic [7:0]  height_lim;
  logic [15:0] total_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd16;
      height_r <= 8'd16;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_WIDTH) begin
        width_r <= cfg_pwdata[7:0];
      end else begin
        height_r <= cfg_pwdata[7:0];
      end
    end
  end

  // read back
  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {24'd0, height_r} : {24'd0, width_r};

  // pixel limit of the glyph, registered after the multiply
  assign width_lim  = (32'(width_r) > MAX_GLYPH_DIM) ? 8'(MAX_GLYPH_DIM) : width_r;
  assign height_lim = (32'(height_r) > MAX_GLYPH_DIM) ? 8'(MAX_GLYPH_DIM) : height_r;
  assign total_nxt  = {8'd0, width_lim} * {8'd0, height_lim};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 16'd256;
    end else begin
      total_r <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/garle_dec.sv -----
`default_nettype none

module garle_dec (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // [7:0] data_byte
  input  wire logic                in_tlast,   // last_byte
  input  wire logic [15:0]         total_r,
  input  wire logic                bundle_free,
  output logic                     bundle_ld,
  output garle_pkg::bundle_t       bundle_nxt
);
  import garle_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [2:0]  mode_r;
  logic [2:0]  mode_nxt;
  logic [1:0]  pcmd_r;
  logic [1:0]  pcmd_nxt;
  logic [3:0]  pcount_r;
  logic [3:0]  pcount_nxt;
  logic [15:0] emitted_r;
  logic [15:0] emitted_nxt;
  logic        s1_adv;
  nib_res_t    n1;
  nib_res_t    n2;
  logic [15:0] left0;
  logic [15:0] left1;
  logic [15:0] left2;
  logic [15:0] len1;
  logic [15:0] len2;
  logic        e1;
  logic        e2;
  run_t        r1;
  run_t        r2;
  run_t        pad;

  assign s1_adv    = s1_valid_r && bundle_free;
  assign in_tready = !s1_valid_r || bundle_free;
  assign bundle_ld = s1_adv;

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // two nibble decodes, high nibble first
  always_comb begin
    left0 = (total_r > emitted_r) ? (total_r - emitted_r) : 16'd0;
    n1    = nib_step(mode_r, pcmd_r, pcount_r, s1_byte_r[7:4]);
    len1  = clip_len(n1.want, n1.rlen, left0);
    left1 = left0 - len1;
    n2    = nib_step(n1.mode, n1.pcmd, n1.pcount, s1_byte_r[3:0]);
    len2  = clip_len(n2.want, n2.rlen, left1);
    left2 = left1 - len2;
    e1    = (len1 != 16'd0);
    e2    = (len2 != 16'd0);
  end

  // pack the runs in order, padding run last
  always_comb begin
    r1  = '{alpha: n1.alpha, len: len1, last: 1'b0};
    r2  = '{alpha: n2.alpha, len: len2, last: 1'b0};
    pad = '{alpha: 8'd0, len: left2, last: 1'b1};
    bundle_nxt.cnt = 2'({1'b0, e1} + {1'b0, e2} + {1'b0, s1_last_r});
    if (e1) begin
      bundle_nxt.slot[0] = r1;
    end else if (e2) begin
      bundle_nxt.slot[0] = r2;
    end else begin
      bundle_nxt.slot[0] = pad;
    end
    bundle_nxt.slot[1] = (e1 && e2) ? r2 : pad;
    bundle_nxt.slot[2] = pad;
  end

  // decoder state update
  always_comb begin
    if (s1_last_r) begin
      mode_nxt    = MODE_CMD;
      pcmd_nxt    = PCMD_ZERO;
      pcount_nxt  = 4'd0;
      emitted_nxt = 16'd0;
    end else begin
      mode_nxt    = n2.mode;
      pcmd_nxt    = n2.pcmd;
      pcount_nxt  = n2.pcount;
      emitted_nxt = emitted_r + len1 + len2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CMD;
      pcmd_r    <= PCMD_ZERO;
      pcount_r  <= 4'd0;
      emitted_r <= 16'd0;
    end else if (s1_adv) begin
      mode_r    <= mode_nxt;
      pcmd_r    <= pcmd_nxt;
      pcount_r  <= pcount_nxt;
      emitted_r <= emitted_nxt;
    end
  end

`include "glyph_alpha_rle_decoder_top_assert.svh"

  `GARLE_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_r, mode_r == MODE_CMD && emitted_r == 16'd0, "decoder not cleared after last word")
  `GARLE_ASSERT_NEXT(a_s1_holds, s1_valid_r && !bundle_free, s1_valid_r && $stable(s1_byte_r), "stalled input word lost")

endmodule

`default_nettype wire

// ----- rtl/garle_outq.sv -----
`default_nettype none

module garle_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               bundle_ld,
  input  wire garle_pkg::bundle_t bundle_nxt,
  output logic                    bundle_free,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [23:0]             out_tdata,   // [7:0] alpha, [23:8] run_length
  output logic                    out_tlast    // last_run
);
  import garle_pkg::*;

  bundle_t    bundle_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       out_fire;
  logic       at_end;
  run_t       cur;

  assign out_tvalid  = (cnt_r != 2'd0);
  assign out_fire    = out_tvalid && out_tready;
  assign at_end      = (idx_r == cnt_r - 2'd1);
  assign bundle_free = (cnt_r == 2'd0) || (out_fire && at_end);

  // serializer control
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (bundle_ld) begin
      cnt_nxt = bundle_nxt.cnt;
      idx_nxt = 2'd0;
    end else if (out_fire) begin
      if (at_end) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (bundle_ld) begin
      bundle_r <= bundle_nxt;
    end
  end

  // current word
  always_comb begin
    unique case (idx_r)
      2'd0:    cur = bundle_r.slot[0];
      2'd1:    cur = bundle_r.slot[1];
      default: cur = bundle_r.slot[2];
    endcase
  end

  assign out_tdata = {cur.len, cur.alpha};
  assign out_tlast = cur.last;

`include "glyph_alpha_rle_decoder_top_assert.svh"

  `GARLE_ASSERT_NOW(a_idx_in_range, cnt_r != 2'd0, idx_r < cnt_r, "slot index past fill count")
  `GARLE_ASSERT_NOW(a_last_is_final, out_tvalid && out_tlast, at_end, "last run not in final slot")

endmodule

`default_nettype wire

// ----- rtl/glyph_alpha_rle_decoder_top.sv -----
// datapath: a byte accepted into the input word register is decoded and loaded
//   into the result register, which puts its first run on the output
// throughput: one byte per cycle while each byte makes at most one run and the
//   output is not stalled; a byte making more runs (up to three) holds the input
//   until the output port, one run per cycle while out_tready is high, takes them all
// reset: synchronous active-low rst_n clears decoder state, queues and sets
//   width and height to 16
`default_nettype none

module glyph_alpha_rle_decoder_top #(
  parameter int unsigned MAX_GLYPH_DIM = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,   // [7:0] alpha, [23:8] run_length
  output logic             out_tlast,   // last_run
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import garle_pkg::*;

  logic [15:0] total_r;
  logic        bundle_free;
  logic        bundle_ld;
  bundle_t     bundle_nxt;

  // configuration registers and pixel limit
  garle_cfg #(
    .MAX_GLYPH_DIM(MAX_GLYPH_DIM)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .total_r     (total_r)
  );

  // input register and nibble decode
  garle_dec u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .total_r     (total_r),
    .bundle_free (bundle_free),
    .bundle_ld   (bundle_ld),
    .bundle_nxt  (bundle_nxt)
  );

  // result register and run serializer
  garle_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle_ld   (bundle_ld),
    .bundle_nxt  (bundle_nxt),
    .bundle_free (bundle_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire
